/* hdl/cwrs_pkg.sv */
// Shared widths, register indexes, constants and types for the chevron wipe row span block.
package cwrs_pkg;

    localparam int W_DIM   = 13;
    localparam int W_STEP  = 16;
    localparam int W_ROW   = 12;
    localparam int W_GS    = 10;
    localparam int W_LVL   = 22;
    localparam int W_IDX   = 3;
    localparam int QUO_W   = 15;
    localparam int PROD_W  = QUO_W + W_STEP;
    localparam int BASE_W  = 18;
    localparam int SLOPE_W = 9;

    localparam int LEVEL_FULL = 256;
    localparam int ZERO_SLOPE = 4;
    localparam int LEVEL_MIN  = -2097152;

    localparam logic [W_IDX-1:0] REG_WIDTH     = 3'd0;
    localparam logic [W_IDX-1:0] REG_HEIGHT    = 3'd1;
    localparam logic [W_IDX-1:0] REG_DIRECTION = 3'd2;
    localparam logic [W_IDX-1:0] REG_GRAD_EN   = 3'd3;
    localparam logic [W_IDX-1:0] REG_GRAD_SIZE = 3'd4;

    typedef struct packed {
        logic [W_DIM-1:0] width;
        logic [W_DIM-1:0] height;
        logic             direction;
        logic             grad_en;
        logic [W_GS-1:0]  grad_size;
    } cwrs_cfg_t;

    typedef struct packed {
        logic [W_STEP-1:0]        rem;
        logic [QUO_W-1:0]         acc;
        logic [W_STEP-1:0]        dvs;
        logic [W_GS-1:0]          srem;
        logic [QUO_W-1:0]         sacc;
        logic [W_GS-1:0]          gsz;
        logic signed [BASE_W-1:0] base;
    } cwrs_cell_t;

endpackage

/* hdl/cwrs_front.sv */
// Entry stage: clamps step and total, forms the sweep product and the row edge offset.
module cwrs_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  cwrs_pkg::cwrs_cfg_t              cfg,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [cwrs_pkg::W_STEP-1:0]      s_frame_step,
    input  logic [cwrs_pkg::W_STEP-1:0]      s_step_total,
    input  logic [cwrs_pkg::W_ROW-1:0]       s_row,
    output logic                             out_valid,
    input  logic                             out_ready,
    output cwrs_pkg::cwrs_cell_t             out_data
);
    import cwrs_pkg::*;

    logic                     valid_reg;
    logic                     valid_next;
    cwrs_cell_t               data_reg;
    cwrs_cell_t               data_next;
    logic [W_STEP-1:0]        total_c;
    logic [W_STEP-1:0]        step_c;
    logic [W_DIM-1:0]         h2;
    logic [W_GS-1:0]          band;
    logic [QUO_W-1:0]         span;
    logic [PROD_W-1:0]        prod;
    logic [BASE_W-1:0]        diff_u;
    logic signed [BASE_W-1:0] tri_v;
    logic signed [BASE_W-1:0] h2_s;
    logic signed [BASE_W-1:0] band_s;
    logic signed [BASE_W-1:0] base;

    assign s_ready   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        total_c = (s_step_total == '0) ? W_STEP'(1) : s_step_total;
        step_c  = (s_frame_step > total_c) ? total_c : s_frame_step;
        h2      = {cfg.height[W_DIM-1:1], 1'b0};
        band    = cfg.grad_en ? cfg.grad_size : '0;
        span    = QUO_W'(h2) + QUO_W'(cfg.width) + QUO_W'(band);
        prod    = PROD_W'(span) * PROD_W'(step_c);
        diff_u  = BASE_W'(cfg.height) - BASE_W'(s_row);
        if (s_row >= cfg.height[W_DIM-1:1]) begin
            tri_v = $signed({diff_u[BASE_W-2:0], 1'b0});
        end else begin
            tri_v = $signed(BASE_W'({s_row, 1'b0}));
        end
        h2_s   = $signed(BASE_W'(h2));
        band_s = $signed(BASE_W'(band));
        if (!cfg.direction) begin
            base = tri_v - h2_s - band_s;
        end else begin
            base = -tri_v - band_s;
        end
        data_next.rem  = prod[PROD_W-1:QUO_W];
        data_next.acc  = prod[QUO_W-1:0];
        data_next.dvs  = total_c;
        data_next.srem = '0;
        data_next.sacc = QUO_W'(LEVEL_FULL);
        data_next.gsz  = cfg.grad_size;
        data_next.base = base;
        valid_next     = s_ready ? s_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_ready && s_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

/* hdl/cwrs_div_cell.sv */
// One restoring division step for the sweep quotient and the gradient slope quotient.
module cwrs_div_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cwrs_pkg::cwrs_cell_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cwrs_pkg::cwrs_cell_t out_data
);
    import cwrs_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    cwrs_cell_t        data_reg;
    cwrs_cell_t        data_next;
    logic [W_STEP:0]   mr2;
    logic [W_STEP:0]   mdiff;
    logic [W_GS:0]     sr2;
    logic [W_GS:0]     sdiff;
    logic              mq;
    logic              sq;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        mr2   = {in_data.rem, in_data.acc[QUO_W-1]};
        mdiff = mr2 - {1'b0, in_data.dvs};
        mq    = !mdiff[W_STEP];
        sr2   = {in_data.srem, in_data.sacc[QUO_W-1]};
        sdiff = sr2 - {1'b0, in_data.gsz};
        sq    = !sdiff[W_GS];
        data_next      = in_data;
        data_next.rem  = mq ? mdiff[W_STEP-1:0] : mr2[W_STEP-1:0];
        data_next.acc  = {in_data.acc[QUO_W-2:0], mq};
        data_next.srem = sq ? sdiff[W_GS-1:0] : sr2[W_GS-1:0];
        data_next.sacc = {in_data.sacc[QUO_W-2:0], sq};
        valid_next     = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

/* hdl/cwrs_back.sv */
// Exit stages: edge position, gradient level and clamped spans into the output register.
module cwrs_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  cwrs_pkg::cwrs_cfg_t             cfg,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  cwrs_pkg::cwrs_cell_t            in_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [cwrs_pkg::W_DIM-1:0]      m_left_span,
    output logic [cwrs_pkg::W_DIM-1:0]      m_grad_span,
    output logic signed [cwrs_pkg::W_LVL-1:0] m_grad_start,
    output logic [cwrs_pkg::W_DIM-1:0]      m_right_span
);
    import cwrs_pkg::*;

    localparam int LVL_P = BASE_W + SLOPE_W + 1;

    logic                     v1_reg;
    logic                     v1_next;
    logic                     rdy1;
    logic signed [BASE_W-1:0] x_reg;
    logic signed [BASE_W-1:0] x_next;
    logic [SLOPE_W-1:0]       slope_reg;
    logic [SLOPE_W-1:0]       slope_next;
    logic [W_GS-1:0]          gsz_reg;

    logic                     mv_reg;
    logic                     mv_next;
    logic [W_DIM-1:0]         left_reg;
    logic [W_DIM-1:0]         left_next;
    logic [W_DIM-1:0]         gspan_reg;
    logic [W_DIM-1:0]         gspan_next;
    logic signed [W_LVL-1:0]  start_reg;
    logic signed [W_LVL-1:0]  start_next;
    logic [W_DIM-1:0]         right_reg;
    logic [W_DIM-1:0]         right_next;

    logic signed [BASE_W:0]   xr;
    logic signed [LVL_P-1:0]  lvl_prod;
    logic signed [LVL_P-1:0]  lvl;
    logic [W_DIM-1:0]         lp;
    logic [W_DIM-1:0]         rp;

    function automatic logic [W_DIM-1:0] span_clamp(input logic signed [BASE_W:0] v,
                                                   input logic [W_DIM-1:0] w);
        logic [W_DIM-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed((BASE_W+1)'(w))) begin
            r = w;
        end else begin
            r = v[W_DIM-1:0];
        end
        return r;
    endfunction

    assign rdy1     = !mv_reg || m_ready;
    assign in_ready = !v1_reg || rdy1;

    assign m_valid      = mv_reg;
    assign m_left_span  = left_reg;
    assign m_grad_span  = gspan_reg;
    assign m_grad_start = start_reg;
    assign m_right_span = right_reg;

    always_comb begin
        x_next     = in_data.base + $signed(BASE_W'(in_data.acc));
        slope_next = (in_data.gsz == '0) ? SLOPE_W'(ZERO_SLOPE) : in_data.sacc[SLOPE_W-1:0];
        v1_next    = in_ready ? in_valid : v1_reg;
    end

    always_comb begin
        xr       = (BASE_W+1)'(x_reg) + $signed((BASE_W+1)'(gsz_reg));
        lvl_prod = x_reg * $signed({1'b0, slope_reg});
        lvl      = LVL_P'(LEVEL_FULL);
        if (x_reg < 0) begin
            lvl = LVL_P'(LEVEL_FULL) + lvl_prod;
        end
        if (lvl < LVL_P'(LEVEL_MIN)) begin
            lvl = LVL_P'(LEVEL_MIN);
        end
        lp = span_clamp((BASE_W+1)'(x_reg), cfg.width);
        rp = span_clamp(xr, cfg.width);
        left_next = lp;
        if (cfg.grad_en) begin
            gspan_next = rp - lp;
            start_next = W_LVL'(lvl);
            right_next = cfg.width - rp;
        end else begin
            gspan_next = '0;
            start_next = '0;
            right_next = '0;
        end
        mv_next = rdy1 ? v1_reg : mv_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            mv_reg <= mv_next;
        end
        if (in_ready && in_valid) begin
            x_reg     <= x_next;
            slope_reg <= slope_next;
            gsz_reg   <= in_data.gsz;
        end
        if (rdy1 && v1_reg) begin
            left_reg  <= left_next;
            gspan_reg <= gspan_next;
            start_reg <= start_next;
            right_reg <= right_next;
        end
    end

endmodule

/* hdl/chevron_wipe_row_span_top.sv */
// Top level of the chevron wipe row span block: registers, entry stage, divider cells, exit.
// Pipeline: an accepted word passes 1 entry stage, 15 divider cells and 2 exit stages
// on the way to its result word; the quotient takes one bit per cell of the chain.
// Throughput: one word per cycle; each stage holds its word while the next one cannot take it.
// Reset: synchronous, active low; clears all valid flags and loads the register defaults
// (width 640, height 480, direction 0, gradient off, gradient size 64).
module chevron_wipe_row_span_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [cwrs_pkg::W_IDX-1:0]        cfg_index,
    input  logic [cwrs_pkg::W_DIM-1:0]        cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [cwrs_pkg::W_STEP-1:0]       s_frame_step,
    input  logic [cwrs_pkg::W_STEP-1:0]       s_step_total,
    input  logic [cwrs_pkg::W_ROW-1:0]        s_row,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [cwrs_pkg::W_DIM-1:0]        m_left_span,
    output logic [cwrs_pkg::W_DIM-1:0]        m_grad_span,
    output logic signed [cwrs_pkg::W_LVL-1:0] m_grad_start,
    output logic [cwrs_pkg::W_DIM-1:0]        m_right_span
);
    import cwrs_pkg::*;

    cwrs_cfg_t  cfg_reg;
    cwrs_cfg_t  cfg_next;
    logic       chain_valid [QUO_W+1];
    logic       chain_ready [QUO_W+1];
    cwrs_cell_t chain_data  [QUO_W+1];

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_WIDTH:     cfg_next.width     = cfg_wr_data;
                REG_HEIGHT:    cfg_next.height    = cfg_wr_data;
                REG_DIRECTION: cfg_next.direction = cfg_wr_data[0];
                REG_GRAD_EN:   cfg_next.grad_en   = cfg_wr_data[0];
                REG_GRAD_SIZE: cfg_next.grad_size = cfg_wr_data[W_GS-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.width     <= W_DIM'(640);
            cfg_reg.height    <= W_DIM'(480);
            cfg_reg.direction <= 1'b0;
            cfg_reg.grad_en   <= 1'b0;
            cfg_reg.grad_size <= W_GS'(64);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    cwrs_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_frame_step (s_frame_step),
        .s_step_total (s_step_total),
        .s_row        (s_row),
        .out_valid    (chain_valid[0]),
        .out_ready    (chain_ready[0]),
        .out_data     (chain_data[0])
    );

    for (genvar i = 0; i < QUO_W; i++) begin : g_cell
        cwrs_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    cwrs_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .in_valid     (chain_valid[QUO_W]),
        .in_ready     (chain_ready[QUO_W]),
        .in_data      (chain_data[QUO_W]),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_left_span  (m_left_span),
        .m_grad_span  (m_grad_span),
        .m_grad_start (m_grad_start),
        .m_right_span (m_right_span)
    );

endmodule
